// ===== design/choc_pkg.sv =====
`timescale 1ns / 1ps

package choc_pkg;

    // table geometry and counter width
    localparam int TABLE_DEPTH = 1024;
    localparam int COUNT_BITS  = 24;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int ID_W     = 32;
    localparam int POS_W    = 16;
    localparam int BIN_W    = 4;
    localparam int BWID_W   = 12;
    localparam int OIDX_W   = 10;
    localparam int HIT_W    = 24;
    localparam int IN_W     = ID_W + 2 * POS_W;
    localparam int OUT_W    = 40;
    localparam int WORD_W   = BIN_W + COUNT_BITS + ID_W;
    localparam int SQ_W     = 2 * POS_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [BIN_W-1:0]      BEYOND_BIN = 4'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TOP  = 2'd2;

    typedef struct packed {
        logic [BWID_W-1:0] bin_width;
        logic [BIN_W-1:0]  bin_count;
        logic              open_top;
    } t_cfg;

    // bin unit handshake
    typedef struct packed {
        logic             done;
        logic [BIN_W-1:0] bin;
    } t_bin_res;

    // one result item
    typedef struct packed {
        logic [BIN_W-1:0]      radial_bin;
        logic                  table_full;
        logic                  new_entry;
        logic [COUNT_BITS-1:0] hit_total;
        logic [IDX_W-1:0]      entry_index;
    } t_result;

endpackage

// ===== design/choc_ram.sv =====
`timescale 1ns / 1ps

module choc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/choc_bin.sv =====
`timescale 1ns / 1ps

module choc_bin
    import choc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [POS_W-1:0] i_x,
    input  logic signed [POS_W-1:0] i_y,
    input  t_cfg                    i_cfg,
    output t_bin_res                o_res
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_X    = 3'd1;
    localparam logic [2:0] B_Y    = 3'd2;
    localparam logic [2:0] B_SUM  = 3'd3;
    localparam logic [2:0] B_SQ   = 3'd4;
    localparam logic [2:0] B_CMP  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [POS_W-1:0]  r_ax, r_ay;
    logic [POS_W-1:0]  r_edge;
    logic [SQ_W-1:0]   r_prod;
    logic [SQ_W-1:0]   r_r2;
    logic [BIN_W-1:0]  r_k;
    logic              r_done;
    logic [BIN_W-1:0]  r_bin;
    logic [POS_W-1:0]  mul_op;
    logic [BIN_W-1:0]  last_k;
    logic [POS_W-1:0]  abs_x, abs_y;

    // magnitudes; the most negative value maps to 2^15 as unsigned
    assign abs_x = i_x[POS_W-1] ? POS_W'(~i_x + 1'b1) : i_x;
    assign abs_y = i_y[POS_W-1] ? POS_W'(~i_y + 1'b1) : i_y;

    // a zero bin count acts as one bin
    assign last_k = (i_cfg.bin_count == '0) ? '0 : i_cfg.bin_count - 1'b1;

    // shared squaring multiplier operand
    always_comb begin
        case (r_state)
            B_X:     mul_op = r_ax;
            B_Y:     mul_op = r_ay;
            default: mul_op = r_edge;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  n_state = B_IDLE;
            B_X:     n_state = B_Y;
            B_Y:     n_state = B_SUM;
            B_SUM:   n_state = B_SQ;
            B_SQ:    n_state = B_CMP;
            B_CMP: begin
                if (r_r2 < r_prod || r_k == last_k) begin
                    n_state = B_IDLE;
                end else begin
                    n_state = B_SQ;
                end
            end
            default: n_state = B_IDLE;
        endcase
        if (i_start) begin
            n_state = B_X;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= !i_start && r_state == B_CMP && n_state == B_IDLE;
        end
    end

    // datapath: x^2 + y^2 then squared edges, one edge per pass through the SQ and CMP states
    always_ff @(posedge i_clk) begin
        r_prod <= SQ_W'(mul_op) * SQ_W'(mul_op);
        if (i_start) begin
            r_ax <= abs_x;
            r_ay <= abs_y;
        end
        case (r_state)
            B_Y:   r_r2 <= r_prod;
            B_SUM: begin
                r_r2   <= r_r2 + r_prod;
                r_edge <= POS_W'(i_cfg.bin_width);
                r_k    <= '0;
            end
            B_CMP: begin
                if (r_r2 < r_prod) begin
                    r_bin <= r_k;
                end else if (r_k == last_k) begin
                    r_bin <= i_cfg.open_top ? last_k : BEYOND_BIN;
                end else begin
                    r_k    <= r_k + 1'b1;
                    r_edge <= r_edge + POS_W'(i_cfg.bin_width);
                end
            end
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.bin  = r_bin;

    a_done_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == B_CMP)
        else $error("bin done without a compare step");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_CMP && !$past(i_start) |-> r_k <= last_k)
        else $error("bin index ran past the last bin");

endmodule

// ===== design/cell_hit_occupancy_counter.sv =====
`timescale 1ns / 1ps
// Each item is searched against the occupied table slots in order, a linear search through the
// single table memory read port, one slot per cycle; a new cell also waits for the bin
// unit before it is appended. The block takes one item at a time and accepts the next
// only after the result has moved to the output register.
// Reset (synchronous, active low) empties the table and loads the default bin settings;
// the table memory itself is not cleared, only the slot count.

module cell_hit_occupancy_counter
    import choc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BWID_W-1:0]    i_cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,  // cell_id[31:0], pos_x[47:32], pos_y[63:48]
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata   // entry_index[9:0], hit_total[33:10],
                                                // new_entry[34], table_full[35],
                                                // radial_bin[39:36]
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]            r_state, n_state;
    t_cfg                  r_cfg;
    logic [USED_W-1:0]     r_used, n_used;
    logic [USED_W-1:0]     r_addr, n_addr;
    logic                  r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_bin_ok, n_bin_ok;
    logic [ID_W-1:0]       r_id;
    t_result               r_res, n_res;
    t_result               r_out;
    logic                  r_ov, n_ov;

    logic                  in_acc;
    logic                  issue;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [WORD_W-1:0]     mem_rdata;
    logic [ID_W-1:0]       rd_id;
    logic [COUNT_BITS-1:0] rd_count;
    logic [BIN_W-1:0]      rd_bin;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  hit;
    logic                  bin_ready;
    logic                  full;
    t_bin_res              bin_res;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bin_width <= 12'd1600;
            r_cfg.bin_count <= 4'd10;
            r_cfg.open_top  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_BIN_WIDTH: r_cfg.bin_width <= i_cfg_data;
                CFG_BIN_COUNT: r_cfg.bin_count <= i_cfg_data[BIN_W-1:0];
                CFG_OPEN_TOP:  r_cfg.open_top  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // radial bin, runs alongside the search
    choc_bin u_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_x     (s_axis_tdata[ID_W +: POS_W]),
        .i_y     (s_axis_tdata[ID_W + POS_W +: POS_W]),
        .i_cfg   (r_cfg),
        .o_res   (bin_res)
    );

    // cell table: {bin, count, id} per slot
    choc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign rd_id     = mem_rdata[ID_W-1:0];
    assign rd_count  = mem_rdata[ID_W +: COUNT_BITS];
    assign rd_bin    = mem_rdata[ID_W + COUNT_BITS +: BIN_W];
    assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
    assign hit       = r_rd_vld && rd_id == r_id;
    assign issue     = r_addr < r_used;
    assign bin_ready = r_bin_ok || bin_res.done;
    assign full      = r_used == USED_W'(TABLE_DEPTH);

    // sequencer: search, then update, append or report a full table, hand off to the output register
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_bin_ok  = r_bin_ok || bin_res.done;
        n_res     = r_res;
        n_ov      = r_ov && !m_axis_tready;
        mem_we    = 1'b0;
        mem_waddr = r_rd_idx;
        mem_wdata = {rd_bin, inc_count, r_id};
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state  = ST_SEARCH;
                    n_addr   = '0;
                    n_bin_ok = 1'b0;
                end
            end
            ST_SEARCH: begin
                // the bin is parked in the result until the append
                if (bin_res.done && !hit) begin
                    n_res.radial_bin = bin_res.bin;
                end
                if (issue) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + 1'b1;
                end
                if (hit) begin
                    mem_we            = 1'b1;
                    n_res.entry_index = r_rd_idx;
                    n_res.hit_total   = inc_count;
                    n_res.new_entry   = 1'b0;
                    n_res.table_full  = 1'b0;
                    n_res.radial_bin  = rd_bin;
                    n_state           = ST_DONE;
                end else if (!r_rd_vld && !issue && full) begin
                    n_res   = '0;
                    n_res.table_full = 1'b1;
                    n_state = ST_DONE;
                end else if (!r_rd_vld && !issue && bin_ready) begin
                    mem_we            = 1'b1;
                    mem_waddr         = r_used[IDX_W-1:0];
                    mem_wdata         = {bin_res.done ? bin_res.bin : r_res.radial_bin,
                                         COUNT_BITS'(1), r_id};
                    n_res.entry_index = r_used[IDX_W-1:0];
                    n_res.hit_total   = COUNT_BITS'(1);
                    n_res.new_entry   = 1'b1;
                    n_res.table_full  = 1'b0;
                    n_res.radial_bin  = bin_res.done ? bin_res.bin : r_res.radial_bin;
                    n_used            = r_used + 1'b1;
                    n_state           = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_bin_ok <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_addr   <= n_addr;
            r_rd_vld <= n_rd_vld;
            r_bin_ok <= n_bin_ok;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (in_acc) begin
            r_id <= s_axis_tdata[ID_W-1:0];
        end
        if (r_state == ST_DONE && (!r_ov || m_axis_tready)) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_out.radial_bin, r_out.table_full, r_out.new_entry,
                            HIT_W'(r_out.hit_total), OIDX_W'(r_out.entry_index)};

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_DEPTH))
        else $error("slot count beyond table depth");

    a_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == ST_SEARCH && n_state == ST_DONE)
        else $error("table write outside the end of a search");

    a_used_grows_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_used != $past(r_used) |->
            $past(mem_we) && r_used == $past(r_used) + 1'b1)
        else $error("slot count changed without an append");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.new_entry && r_out.table_full))
        else $error("result both new and dropped");

endmodule
